FILE: src/ppr_pkg.sv
// ----------------------------------------------------------------------------
// Polygon prism region package
// Shared widths, codes and the control and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ppr_pkg;

	localparam int MAX_VERTICES      = 64;
	localparam int COORD_BITS        = 26;
	localparam int MIN_POLY_VERTICES = 3;
	localparam int Y_W               = 12;
	localparam int DIM_W             = 2;
	localparam int STATUS_W          = 2;
	localparam int VOL_W             = 63;

	localparam int AW     = $clog2(MAX_VERTICES);
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int DW     = COORD_BITS + 1;
	localparam int PW     = 2 * DW;
	localparam int ACC_W  = PW + AW + 1;
	localparam int AREA_W = ACC_W - 1;
	localparam int HW     = Y_W + 1;
	localparam int MP_W   = (AREA_W + HW > VOL_W) ? AREA_W + HW : VOL_W + 1;
	localparam int K_W    = (CNT_W > $clog2(HW)) ? CNT_W : $clog2(HW);
	localparam int DRAIN_CYCLES = 3;

	typedef enum logic [1:0] {
		KIND_START    = 2'd0,
		KIND_ADD      = 2'd1,
		KIND_CONTAINS = 2'd2,
		KIND_VOLUME   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		RES_OK     = 2'd0,
		RES_REJECT = 2'd1,
		RES_FULL   = 2'd2
	} res_status_t;

	typedef enum logic [0:0] {
		REG_WORLD_BOTTOM = 1'b0,
		REG_WORLD_TOP    = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_DRAIN,
		S_DECIDE,
		S_MUL,
		S_RESP
	} ctrl_state_t;

	typedef struct packed {
		logic          load;
		logic          rd_en;
		logic          prime;
		logic [AW-1:0] rd_addr;
		logic          decide;
		logic          mul_step;
	} dp_cmd_t;

	typedef struct packed {
		kind_t            kind;
		logic [CNT_W-1:0] count;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: src/polygon_prism_region_top.sv
// ----------------------------------------------------------------------------
// Polygon prism region
// Keeps a polygonal prism and answers vertex adds, contains and volume queries.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears with done for exactly one cycle and cannot be held off. Add,
// contains and volume items walk the vertex store through its one read port,
// one vertex per cycle, unless the store is empty; a volume item then adds a
// bit-serial multiply of the area by the span height. A rejected add still
// walks the store. The world limit registers are written through the cfg
// channel, which is always ready.
`default_nettype none

module polygon_prism_region_top
	import ppr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            kind,
	input  wire logic [COORD_BITS-1:0] pos_x,
	input  wire logic [Y_W-1:0]        pos_y,
	input  wire logic [COORD_BITS-1:0] pos_z,
	input  wire logic [DIM_W-1:0]      dimension,
	output logic                       done,
	output logic [STATUS_W-1:0]        status,
	output logic                       inside_res,
	output logic [VOL_W-1:0]           volume,
	output logic [CNT_W-1:0]           vertex_total,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [0:0]            cfg_index,
	input  wire logic [Y_W-1:0]        cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	ppr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ppr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (kind),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.dimension    (dimension),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.status       (status),
		.inside_res   (inside_res),
		.volume       (volume),
		.vertex_total (vertex_total)
	);

endmodule

`default_nettype wire

FILE: src/ppr_ctrl.sv
// ----------------------------------------------------------------------------
// Polygon prism region controller
// Sequences the vertex walk, the pipeline drain, the state update and the
// bit-serial volume multiply, and raises the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module ppr_ctrl
	import ppr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic [1:0] kind,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd,
	output logic          busy,
	output logic          done
);

	ctrl_state_t state_q, state_d;
	logic [K_W-1:0] k_q, k_d;
	logic [CNT_W-1:0] last_idx;
	logic [CNT_W-1:0] prev_idx;

	assign last_idx = stat.count - CNT_W'(1);
	assign prev_idx = k_q[CNT_W-1:0] - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		k_d          = k_q;
		cmd          = '0;
		busy         = (state_q != S_IDLE);
		done         = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					k_d      = '0;
					if (kind_t'(kind) != KIND_START && stat.count != '0)
						state_d = S_WALK;
					else
						state_d = S_DECIDE;
				end
			end
			S_WALK: begin
				// The walk opens with the last vertex so that every edge has its
				// previous corner at hand.
				cmd.rd_en   = 1'b1;
				cmd.prime   = (k_q == '0);
				cmd.rd_addr = (k_q == '0) ? last_idx[AW-1:0] : prev_idx[AW-1:0];
				if (k_q[CNT_W-1:0] == stat.count) begin
					k_d     = '0;
					state_d = S_DRAIN;
				end else begin
					k_d = k_q + K_W'(1);
				end
			end
			S_DRAIN: begin
				if (k_q == K_W'(DRAIN_CYCLES - 1)) begin
					k_d     = '0;
					state_d = S_DECIDE;
				end else begin
					k_d = k_q + K_W'(1);
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				k_d        = '0;
				if (stat.kind == KIND_VOLUME)
					state_d = S_MUL;
				else
					state_d = S_RESP;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (k_q == K_W'(HW - 1)) begin
					k_d     = '0;
					state_d = S_RESP;
				end else begin
					k_d = k_q + K_W'(1);
				end
			end
			S_RESP: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe outside a busy period");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item did not start work");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("block still busy after result");

	a_read_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (stat.count != '0)) else $error("vertex read with empty store");

endmodule

`default_nettype wire

FILE: src/ppr_dp.sv
// ----------------------------------------------------------------------------
// Polygon prism region datapath
// Vertex store, region state, world limits, the two-stage edge pipeline for
// the crossing test and shoelace sum, and the bit-serial volume multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module ppr_dp
	import ppr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dp_cmd_t               cmd,
	output dp_stat_t                   stat,
	input  wire logic [1:0]            kind,
	input  wire logic [COORD_BITS-1:0] pos_x,
	input  wire logic [Y_W-1:0]        pos_y,
	input  wire logic [COORD_BITS-1:0] pos_z,
	input  wire logic [DIM_W-1:0]      dimension,
	input  wire logic                  cfg_we,
	input  wire logic [0:0]            cfg_index,
	input  wire logic [Y_W-1:0]        cfg_data,
	output logic [STATUS_W-1:0]        status,
	output logic                       inside_res,
	output logic [VOL_W-1:0]           volume,
	output logic [CNT_W-1:0]           vertex_total
);

	logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
	logic [2*COORD_BITS-1:0] mem_q;
	logic                    rv_q, prime_q;

	kind_t                          kind_q;
	logic signed [COORD_BITS-1:0]   px_q, pz_q;
	logic signed [Y_W-1:0]          py_q;
	logic [DIM_W-1:0]               idim_q;

	logic signed [Y_W-1:0] bottom_q, top_q;
	logic signed [Y_W-1:0] span_lo_q, span_hi_q;
	logic [CNT_W-1:0]      count_q;
	logic                  started_q;
	logic [DIM_W-1:0]      rdim_q;

	logic signed [COORD_BITS-1:0] prev_x_q, prev_z_q;

	logic                 rv_s1, pr_s1, eq_s1, inr_s1, x1ne_s1, zc_s1;
	logic signed [PW-1:0] p1_s1, p2_s1;

	logic                    found_q, hit_q, parity_q, inside_q;
	logic signed [ACC_W-1:0] acc_q;
	res_status_t             status_q;

	logic [MP_W-1:0] ma_q, prod_q;
	logic [HW-1:0]   mh_q;

	// Edge stage.
	logic signed [COORD_BITS-1:0] cx, cz, x1, z1, x2, z2;
	logic                         swap;
	logic signed [DW-1:0]         a1, b1, a2, b2;
	logic signed [PW-1:0]         p1, p2;
	logic signed [PW:0]           cr;

	assign cx   = mem_q[2*COORD_BITS-1:COORD_BITS];
	assign cz   = mem_q[COORD_BITS-1:0];
	assign swap = cx > prev_x_q;
	assign x1   = swap ? prev_x_q : cx;
	assign z1   = swap ? prev_z_q : cz;
	assign x2   = swap ? cx : prev_x_q;
	assign z2   = swap ? cz : prev_z_q;

	always_comb begin
		if (kind_q == KIND_VOLUME) begin
			a1 = DW'(prev_x_q) + DW'(cx);
			b1 = DW'(prev_z_q) - DW'(cz);
			a2 = '0;
			b2 = '0;
		end else begin
			a1 = DW'(pz_q) - DW'(z1);
			b1 = DW'(x2) - DW'(x1);
			a2 = DW'(z2) - DW'(z1);
			b2 = DW'(px_q) - DW'(x1);
		end
	end

	assign p1 = PW'(a1) * PW'(b1);
	assign p2 = PW'(a2) * PW'(b2);
	assign cr = (PW+1)'(p1_s1) - (PW+1)'(p2_s1);

	// Span update and clamp to the world limits.
	logic signed [Y_W:0]   top_m1;
	logic signed [Y_W-1:0] top_lim, lo_raw, hi_raw, lo_new, hi_new;

	assign top_m1  = (Y_W+1)'(top_q) - (Y_W+1)'(1);
	assign top_lim = (top_m1 < -(Y_W+1)'(2 ** (Y_W - 1))) ?
		Y_W'(-(2 ** (Y_W - 1))) : top_m1[Y_W-1:0];

	always_comb begin
		if (kind_q == KIND_START) begin
			lo_raw = py_q;
			hi_raw = py_q;
		end else begin
			lo_raw = (py_q < span_lo_q) ? py_q : span_lo_q;
			hi_raw = (py_q > span_hi_q) ? py_q : span_hi_q;
		end
		lo_new = (lo_raw < bottom_q) ? bottom_q : lo_raw;
		hi_new = (hi_raw > top_lim) ? top_lim : hi_raw;
	end

	logic reject, full, apply_add;
	assign reject    = !started_q || (idim_q != rdim_q);
	assign full      = !found_q && (count_q == CNT_W'(MAX_VERTICES));
	assign apply_add = !reject && !full;

	logic signed [Y_W+1:0] h;
	logic                  h_pos;
	logic [ACC_W-1:0]      acc_abs;
	logic [AREA_W-1:0]     area;
	logic                  in_span;

	assign h       = (Y_W+2)'(span_hi_q) - (Y_W+2)'(span_lo_q) + (Y_W+2)'(1);
	assign h_pos   = !h[Y_W+1] && (h != '0);
	assign acc_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign area    = acc_abs[ACC_W-1:1];
	assign in_span = (py_q >= span_lo_q) && (py_q <= span_hi_q);

	logic                    we;
	logic [AW-1:0]           wr_addr;
	assign we      = cmd.decide && ((kind_q == KIND_START) ||
		(kind_q == KIND_ADD && apply_add && !found_q));
	assign wr_addr = (kind_q == KIND_START) ? '0 : count_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= {px_q, pz_q};
		if (cmd.rd_en)
			mem_q <= mem[cmd.rd_addr];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q      <= 1'b0;
			rv_s1     <= 1'b0;
			bottom_q  <= -Y_W'(64);
			top_q     <= Y_W'(320);
			span_lo_q <= '0;
			span_hi_q <= '0;
			count_q   <= '0;
			started_q <= 1'b0;
			rdim_q    <= '0;
		end else begin
			rv_q  <= cmd.rd_en;
			rv_s1 <= rv_q;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_WORLD_BOTTOM: bottom_q <= cfg_data;
					REG_WORLD_TOP:    top_q    <= cfg_data;
					default:          ;
				endcase
			end
			if (cmd.decide) begin
				if (kind_q == KIND_START) begin
					started_q <= 1'b1;
					rdim_q    <= idim_q;
					count_q   <= CNT_W'(1);
					span_lo_q <= lo_new;
					span_hi_q <= hi_new;
				end else if (kind_q == KIND_ADD && apply_add) begin
					span_lo_q <= lo_new;
					span_hi_q <= hi_new;
					if (!found_q)
						count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= kind_t'(kind);
			px_q     <= pos_x;
			py_q     <= pos_y;
			pz_q     <= pos_z;
			idim_q   <= dimension;
			found_q  <= 1'b0;
			hit_q    <= 1'b0;
			parity_q <= 1'b0;
			acc_q    <= '0;
			inside_q <= 1'b0;
			prod_q   <= '0;
		end
		if (cmd.rd_en)
			prime_q <= cmd.prime;
		if (rv_q) begin
			prev_x_q <= cx;
			prev_z_q <= cz;
			pr_s1    <= prime_q;
			eq_s1    <= (cx == px_q) && (cz == pz_q);
			inr_s1   <= (x1 <= px_q) && (px_q <= x2);
			x1ne_s1  <= (x1 != px_q);
			zc_s1    <= ((z1 <= pz_q) == (pz_q <= z2));
			p1_s1    <= p1;
			p2_s1    <= p2;
		end
		if (rv_s1) begin
			if (eq_s1)
				found_q <= 1'b1;
			if (!pr_s1) begin
				if (kind_q == KIND_CONTAINS) begin
					if (eq_s1) begin
						hit_q <= 1'b1;
					end else if (inr_s1) begin
						if (cr == '0) begin
							if (zc_s1)
								hit_q <= 1'b1;
						end else if (cr[PW] && x1ne_s1) begin
							parity_q <= !parity_q;
						end
					end
				end
				if (kind_q == KIND_VOLUME)
					acc_q <= acc_q + ACC_W'(p1_s1);
			end
		end
		if (cmd.decide) begin
			if (kind_q == KIND_ADD && reject)
				status_q <= RES_REJECT;
			else if (kind_q == KIND_ADD && full)
				status_q <= RES_FULL;
			else
				status_q <= RES_OK;
			if (kind_q == KIND_CONTAINS)
				inside_q <= (count_q >= CNT_W'(MIN_POLY_VERTICES)) && in_span &&
					(hit_q || parity_q);
			if (kind_q == KIND_VOLUME) begin
				ma_q   <= MP_W'(area);
				mh_q   <= h_pos ? h[HW-1:0] : '0;
				prod_q <= '0;
			end
		end
		if (cmd.mul_step) begin
			if (mh_q[0])
				prod_q <= prod_q + ma_q;
			ma_q <= ma_q << 1;
			mh_q <= mh_q >> 1;
		end
	end

	logic [VOL_W-1:0] vol_sat;
	assign vol_sat = (prod_q[MP_W-1:VOL_W] != '0) ? '1 : prod_q[VOL_W-1:0];

	assign status       = status_q;
	assign inside_res   = (kind_q == KIND_CONTAINS) && inside_q;
	assign volume       = (kind_q == KIND_VOLUME) ? vol_sat : '0;
	assign vertex_total = count_q;
	assign stat.kind    = kind_q;
	assign stat.count   = count_q;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES)) else $error("vertex count beyond store depth");

	a_count_started: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> started_q) else $error("vertices stored without a region");

endmodule

`default_nettype wire
